>>> sv/cce_pkg.sv
// Shared types and constants for the text console character engine.
// No dependencies; used by text_console_char_engine.
`timescale 1ns / 1ps

package cce_pkg;

  localparam int FUNC_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ADDR_W      = 11;
  localparam int CELL_W      = 16;
  localparam int LOC_W       = 11;
  localparam int COLOUR_W    = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Operation codes carried in tuser
  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'b1;

  localparam logic [COLOUR_W-1:0] BACKGROUND_RESET = 4'h3;
  localparam logic [COLOUR_W-1:0] FOREGROUND_RESET = 4'hF;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_HT    = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

>>> sv/cce_ram.sv
// Cell store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module cce_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/text_console_char_engine.sv
// Text console character engine: top level with sequencer and cursor logic.
// Depends on cce_pkg and cce_ram.
`timescale 1ns / 1ps

// Usage:
//   Slave channel s_*: one word per operation; tuser selects put character,
//   clear screen or read cell. Master channel m_*: exactly one result word per
//   operation, carrying the cursor location, read data and the scroll flag.
//   Colours are written through cfg_we/cfg_index/cfg_data while idle.
// Operations (one at a time, serialised by the single write and read
// port of the cell store; a new word is taken only in the idle state):
//   put without scroll: the cell, if any, is written on accept; read: the
//   registered read is captured; clear: one blank written per cycle;
//   put that scrolls: row copy one cell per cycle through
//   the read-then-write pipeline, then the last row blanked.
// Reset: the cell store is swept to zero, one cell per cycle, all COLUMNS*ROWS
//   cells (2000 by default); s_tready stays low meanwhile. Cursor homes,
//   colours return to background 3, foreground 15.
// Stall: a result sits in the output register until m_tready; the next
//   operation is accepted meanwhile and waits in its final state if the
//   output register is still full when it finishes.
module text_console_char_engine #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] char_code, [18:8] cell_address, [23:19] zero
  input  logic [cce_pkg::IN_TDATA_W-1:0]      s_tdata,
  // [1:0] func
  input  logic [cce_pkg::FUNC_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [10:0] cursor_location, [26:11] cell_data, [27] scrolled, [31:28] zero
  output logic [cce_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [cce_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cce_pkg::COLOUR_W-1:0]        cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_N     = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);
  localparam int CLW        = $clog2(COLUMNS);
  localparam int CTW        = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW         = $clog2(ROWS);
  localparam int PW         = $clog2(TAB_WIDTH);

  // Input fields
  logic [cce_pkg::CHAR_W-1:0] in_char;
  logic [cce_pkg::ADDR_W-1:0] in_addr;

  assign in_char = s_tdata[cce_pkg::CHAR_W-1:0];
  assign in_addr = s_tdata[cce_pkg::CHAR_W +: cce_pkg::ADDR_W];

  // Registers
  cce_pkg::state_t state, state_next;
  logic [CW-1:0]   sweep, sweep_next;
  logic [CLW-1:0]  cur_col, cur_col_next;
  logic [RW-1:0]   cur_row, cur_row_next;
  logic [PW-1:0]   tab_phase, tab_phase_next;
  logic [cce_pkg::CELL_W-1:0] res_data, res_data_next;
  logic            res_scrolled, res_scrolled_next;
  logic [cce_pkg::COLOUR_W-1:0] background, foreground;
  logic            out_load;
  logic [cce_pkg::LOC_W-1:0]  out_loc;
  logic [cce_pkg::CELL_W-1:0] out_data;
  logic            out_scr;

  // Memory port
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [cce_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

  logic [cce_pkg::CELL_W-1:0] blank_word;
  logic [AW-1:0]              cur_idx;

  assign blank_word = {background, foreground, cce_pkg::CHAR_SPACE};
  assign cur_idx    = AW'(cur_row) * AW'(COLUMNS) + AW'(cur_col);

  // Put-character decode
  logic [CTW-1:0] put_col;
  logic [RW:0]    put_row;
  logic [PW-1:0]  put_phase;
  logic           put_we;
  logic [AW-1:0]  put_waddr;
  logic [cce_pkg::CELL_W-1:0] put_wdata;
  logic           put_scroll;

  always_comb begin
    put_col   = CTW'(cur_col);
    put_row   = {1'b0, cur_row};
    put_phase = tab_phase;
    put_we    = 1'b0;
    put_waddr = cur_idx;
    put_wdata = {background, foreground, in_char};
    if (in_char == cce_pkg::CHAR_BS && cur_col != '0) begin
      put_col   = CTW'(cur_col) - CTW'(1);
      put_phase = (tab_phase == '0) ? PW'(TAB_WIDTH - 1) : tab_phase - PW'(1);
      put_we    = 1'b1;
      put_waddr = cur_idx - AW'(1);
      put_wdata = blank_word;
    end else if (in_char == cce_pkg::CHAR_HT) begin
      put_col   = CTW'(cur_col) + CTW'(TAB_WIDTH) - CTW'(tab_phase);
      put_phase = '0;
    end else if (in_char == cce_pkg::CHAR_LF || in_char == cce_pkg::CHAR_CR) begin
      put_col   = '0;
      put_row   = {1'b0, cur_row} + (RW+1)'(1);
      put_phase = '0;
    end else if (in_char inside {[cce_pkg::CHAR_SPACE:cce_pkg::CHAR_LAST]}) begin
      put_col   = CTW'(cur_col) + CTW'(1);
      put_phase = (tab_phase == PW'(TAB_WIDTH - 1)) ? '0 : tab_phase + PW'(1);
      put_we    = 1'b1;
    end
    // wrap at the right edge
    if (put_col >= CTW'(COLUMNS)) begin
      put_col   = '0;
      put_row   = put_row + (RW+1)'(1);
      put_phase = '0;
    end
    put_scroll = (put_row >= (RW+1)'(ROWS));
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    sweep_next        = sweep;
    cur_col_next      = cur_col;
    cur_row_next      = cur_row;
    tab_phase_next    = tab_phase;
    res_data_next     = res_data;
    res_scrolled_next = res_scrolled;
    out_load          = 1'b0;
    s_tready          = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = AW'(sweep);
    mem_wdata         = blank_word;
    mem_re            = 1'b0;
    mem_raddr         = AW'(in_addr);
    case (state)
      cce_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (sweep == CW'(CELL_COUNT - 1)) begin
          sweep_next = '0;
          state_next = cce_pkg::ST_IDLE;
        end else begin
          sweep_next = sweep + CW'(1);
        end
      end
      cce_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          res_data_next     = '0;
          res_scrolled_next = 1'b0;
          state_next        = cce_pkg::ST_DONE;
          case (s_tuser)
            cce_pkg::FN_PUT: begin
              mem_we            = put_we;
              mem_waddr         = put_waddr;
              mem_wdata         = put_wdata;
              cur_col_next      = CLW'(put_col);
              cur_row_next      = RW'(put_row);
              tab_phase_next    = put_phase;
              res_scrolled_next = put_scroll;
              if (put_scroll) begin
                cur_row_next = RW'(ROWS - 1);
                sweep_next   = '0;
                state_next   = cce_pkg::ST_COPY;
              end
            end
            cce_pkg::FN_CLEAR: begin
              cur_col_next   = '0;
              cur_row_next   = '0;
              tab_phase_next = '0;
              sweep_next     = '0;
              state_next     = cce_pkg::ST_FILL;
            end
            cce_pkg::FN_READ: begin
              if (32'(in_addr) < CELL_COUNT) begin
                mem_re     = 1'b1;
                state_next = cce_pkg::ST_READ;
              end
            end
            default: begin
              state_next = cce_pkg::ST_DONE;
            end
          endcase
        end
      end
      cce_pkg::ST_READ: begin
        res_data_next = mem_rdata;
        state_next    = cce_pkg::ST_DONE;
      end
      cce_pkg::ST_COPY: begin
        // read cell sweep+COLUMNS, write the word read last cycle to sweep-1
        mem_re    = (sweep < CW'(COPY_N));
        mem_raddr = AW'(sweep + CW'(COLUMNS));
        mem_we    = (sweep != '0);
        mem_waddr = AW'(sweep - CW'(1));
        mem_wdata = mem_rdata;
        if (sweep == CW'(COPY_N)) begin
          state_next = cce_pkg::ST_FILL;
        end else begin
          sweep_next = sweep + CW'(1);
        end
      end
      cce_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (sweep == CW'(CELL_COUNT - 1)) begin
          state_next = cce_pkg::ST_DONE;
        end else begin
          sweep_next = sweep + CW'(1);
        end
      end
      cce_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = cce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cce_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cce_pkg::ST_INIT;
      sweep     <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      tab_phase <= '0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      tab_phase <= tab_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    res_data     <= res_data_next;
    res_scrolled <= res_scrolled_next;
  end

  // Colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      background <= cce_pkg::BACKGROUND_RESET;
      foreground <= cce_pkg::FOREGROUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cce_pkg::CFG_BACKGROUND: background <= cfg_data;
        cce_pkg::CFG_FOREGROUND: foreground <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_loc  <= cce_pkg::LOC_W'(cur_idx);
      out_data <= res_data;
      out_scr  <= res_scrolled;
    end
  end

  assign m_tdata = {4'b0, out_scr, out_data, out_loc};

  cce_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW),
    .DW    (cce_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Checks
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("cell store read and write hit the same cell");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_row) < ROWS)
    else $error("cursor row beyond last row");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == cce_pkg::ST_DONE))
    else $error("result word raised outside the done state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != cce_pkg::ST_IDLE))
    else $error("accepted word did not start an operation");

endmodule
